[rtl/cmvm_pkg.sv]
package cmvm_pkg;

    // Row sums are Q10.30, wrapped to this width
    localparam int SUM_W = 40;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_NUM_COLS = 2'd0;
    localparam reg_idx_t REG_NUM_ROWS = 2'd1;
    localparam reg_idx_t REG_VEC_LEN  = 2'd2;

    // Input item kinds
    localparam logic KIND_VECTOR = 1'b0;
    localparam logic KIND_MATRIX = 1'b1;

endpackage

[rtl/complex_matrix_vector_multiply.sv]
// Complex matrix times complex vector, fixed point, no conjugation.
// Input channel (s_*): one beat is either a vector element (s_kind = 0),
// written to the vector store at s_position, or the next matrix element in
// row-major order (s_kind = 1). Each matrix element is multiplied by the
// stored vector element of its column and summed; columns at or beyond
// vec_len add nothing. Elements are Q1.15, row sums Q10.30, exact.
// Result channel (m_*): one beat at the end of every row, carrying the row
// number, the complex row sum and a flag on the final row of the matrix.
// Configuration: APB-style, num_cols at 0x0, num_rows at 0x4, vec_len at 0x8;
// write only while no matrix is in flight.
// Throughput: one beat per clock while s_ready is high. The multiply-accumulate is a
// three-stage pipe: store read, four products, accumulate into the output
// register. A row's last beat passes the stage-one and product registers
// before its sum is loaded into the output register and m_valid rises.
// Stall: a waiting result does not block the input; only when a row-end
// beat reaches the accumulator while the output register is still full does
// s_ready drop, and the whole pipe holds until the result is taken.
// Reset: counters and accumulators cleared, all sizes min(MAX_DIM, 64). The vector store
// is not cleared; an entry must be written before a used column reads it.
module complex_matrix_vector_multiply
    import cmvm_pkg::*;
#(
    parameter int MAX_DIM     = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [$clog2(MAX_DIM)-1:0]    s_position,
    input  logic signed [SAMPLE_BITS-1:0] s_elem_re,
    input  logic signed [SAMPLE_BITS-1:0] s_elem_im,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [$clog2(MAX_DIM)-1:0]    m_row_index,
    output logic signed [SUM_W-1:0]       m_sum_re,
    output logic signed [SUM_W-1:0]       m_sum_im,
    output logic                          m_last_row
);

    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int CFG_W   = $clog2(MAX_DIM + 1);
    localparam int SB      = SAMPLE_BITS;
    localparam int PW      = 2 * SAMPLE_BITS;
    localparam int XW      = (PW + 1 > SUM_W) ? PW + 1 : SUM_W;
    localparam int CFG_RST = (MAX_DIM < 64) ? MAX_DIM : 64;

    localparam logic [CFG_W-1:0] DIM_MAX = CFG_W'(MAX_DIM);
    localparam logic [CFG_W-1:0] ONE_CFG = CFG_W'(1);

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] num_cols_reg, num_rows_reg, vec_len_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg <= CFG_W'(CFG_RST);
            num_rows_reg <= CFG_W'(CFG_RST);
            vec_len_reg  <= CFG_W'(CFG_RST);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_NUM_COLS: num_cols_reg <= pwdata[CFG_W-1:0];
                REG_NUM_ROWS: num_rows_reg <= pwdata[CFG_W-1:0];
                REG_VEC_LEN:  vec_len_reg  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_NUM_COLS: prdata = PDATA_W'(num_cols_reg);
            REG_NUM_ROWS: prdata = PDATA_W'(num_rows_reg);
            REG_VEC_LEN:  prdata = PDATA_W'(vec_len_reg);
            default:      prdata = '0;
        endcase
    end

    // Effective sizes: 0 acts as 1 for cols/rows, anything above MAX_DIM clamps
    logic [CFG_W-1:0] cols_eff, rows_eff, vlen_eff;

    always_comb begin
        cols_eff = (num_cols_reg == '0) ? ONE_CFG :
                   (num_cols_reg > DIM_MAX) ? DIM_MAX : num_cols_reg;
        rows_eff = (num_rows_reg == '0) ? ONE_CFG :
                   (num_rows_reg > DIM_MAX) ? DIM_MAX : num_rows_reg;
        vlen_eff = (vec_len_reg > DIM_MAX) ? DIM_MAX : vec_len_reg;
    end

    // ---------------- pipe control ----------------
    logic advance, s_accept;
    logic s1_valid_reg, s2_valid_reg, s2_end_reg;
    logic m_valid_reg;

    // Hold only when a row sum is due and the output register cannot take it
    assign advance  = !(s2_valid_reg && s2_end_reg && m_valid_reg && !m_ready);
    assign s_ready  = advance;
    assign s_accept = s_valid && s_ready;

    // ---------------- column / row counters ----------------
    logic [POS_W-1:0] col_count_reg, row_count_reg;
    logic             item_use, item_end, item_last;

    always_comb begin
        item_use  = CFG_W'(col_count_reg) < vlen_eff;
        item_end  = (CFG_W'(col_count_reg) + ONE_CFG) >= cols_eff;
        item_last = (CFG_W'(row_count_reg) + ONE_CFG) >= rows_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (s_accept && s_kind == KIND_MATRIX) begin
            if (item_end) begin
                col_count_reg <= '0;
                row_count_reg <= item_last ? '0 : row_count_reg + POS_W'(1);
            end else begin
                col_count_reg <= col_count_reg + POS_W'(1);
            end
        end
    end

    // ---------------- vector store ----------------
    logic [2*SB-1:0] vec_mem [MAX_DIM];
    logic [2*SB-1:0] s1_b_reg;
    logic            pos_ok;

    assign pos_ok = 32'(s_position) < 32'(MAX_DIM);

    always_ff @(posedge aclk) begin
        if (s_accept && s_kind == KIND_VECTOR && pos_ok) begin
            vec_mem[s_position] <= {s_elem_re, s_elem_im};
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_kind == KIND_MATRIX) begin
            s1_b_reg <= vec_mem[col_count_reg];
        end
    end

    // ---------------- stage 1: element and flags ----------------
    logic signed [SB-1:0] s1_a_re_reg, s1_a_im_reg;
    logic                 s1_use_reg, s1_end_reg, s1_last_reg;
    logic [POS_W-1:0]     s1_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_accept && s_kind == KIND_MATRIX;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_a_re_reg <= s_elem_re;
            s1_a_im_reg <= s_elem_im;
            s1_use_reg  <= item_use;
            s1_end_reg  <= item_end;
            s1_last_reg <= item_last;
            s1_row_reg  <= row_count_reg;
        end
    end

    // ---------------- stage 2: four products ----------------
    logic signed [SB-1:0] s1_b_re, s1_b_im;
    logic signed [PW-1:0] s2_rr_reg, s2_ii_reg, s2_ri_reg, s2_ir_reg;
    logic                 s2_last_reg;
    logic [POS_W-1:0]     s2_row_reg;

    assign s1_b_re = s1_b_reg[2*SB-1:SB];
    assign s1_b_im = s1_b_reg[SB-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_end_reg  <= s1_end_reg;
            s2_last_reg <= s1_last_reg;
            s2_row_reg  <= s1_row_reg;
            if (s1_use_reg) begin
                s2_rr_reg <= s1_a_re_reg * s1_b_re;
                s2_ii_reg <= s1_a_im_reg * s1_b_im;
                s2_ri_reg <= s1_a_re_reg * s1_b_im;
                s2_ir_reg <= s1_a_im_reg * s1_b_re;
            end else begin
                // column beyond vec_len: contributes nothing
                s2_rr_reg <= '0;
                s2_ii_reg <= '0;
                s2_ri_reg <= '0;
                s2_ir_reg <= '0;
            end
        end
    end

    // ---------------- stage 3: accumulate ----------------
    logic signed [XW-1:0]    prod_re, prod_im;
    logic signed [SUM_W-1:0] acc_re_reg, acc_im_reg;
    logic signed [SUM_W-1:0] acc_re_next, acc_im_next;
    logic                    row_done;

    always_comb begin
        prod_re = signed'({{(XW-PW){s2_rr_reg[PW-1]}}, s2_rr_reg})
                - signed'({{(XW-PW){s2_ii_reg[PW-1]}}, s2_ii_reg});
        prod_im = signed'({{(XW-PW){s2_ri_reg[PW-1]}}, s2_ri_reg})
                + signed'({{(XW-PW){s2_ir_reg[PW-1]}}, s2_ir_reg});
        acc_re_next = acc_re_reg + signed'(prod_re[SUM_W-1:0]);
        acc_im_next = acc_im_reg + signed'(prod_im[SUM_W-1:0]);
    end

    assign row_done = advance && s2_valid_reg && s2_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (advance && s2_valid_reg) begin
            if (s2_end_reg) begin
                acc_re_reg <= '0;
                acc_im_reg <= '0;
            end else begin
                acc_re_reg <= acc_re_next;
                acc_im_reg <= acc_im_next;
            end
        end
    end

    // ---------------- output register ----------------
    logic                    m_valid_next;
    logic [POS_W-1:0]        m_row_reg;
    logic signed [SUM_W-1:0] m_sum_re_reg, m_sum_im_reg;
    logic                    m_last_reg;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (row_done) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (row_done) begin
            m_row_reg    <= s2_row_reg;
            m_sum_re_reg <= acc_re_next;
            m_sum_im_reg <= acc_im_next;
            m_last_reg   <= s2_last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_row_index = m_row_reg;
    assign m_sum_re    = m_sum_re_reg;
    assign m_sum_im    = m_sum_im_reg;
    assign m_last_row  = m_last_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && s2_valid_reg && s2_end_reg))
        else $error("input stalled without a blocked row sum");

    a_row_sum_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        row_done |=> m_valid)
        else $error("row end did not load the output register");

    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        row_done |=> (acc_re_reg == '0 && acc_im_reg == '0))
        else $error("accumulator not cleared after row end");

    a_counters_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(col_count_reg) < 32'(MAX_DIM)) && (32'(row_count_reg) < 32'(MAX_DIM)))
        else $error("column or row counter beyond MAX_DIM");
`endif

endmodule
